@@ rtl/circ_pkg.sv @@
// Shared constants for the midpoint circle rasterizer.
`timescale 1ns / 1ps
package circ_pkg;

  // Item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Fixed field widths
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned COLOR_W = 8;

  // Decision value constants
  localparam int unsigned D_INIT      = 3;
  localparam int unsigned D_STEP_DIAG = 10;
  localparam int unsigned D_STEP_FLAT = 6;

  // Octant jobs held between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Pixels per job, last pixel index
  localparam logic [2:0] PIX_LAST = 3'd7;

endpackage

@@ rtl/circ_front.sv @@
// Front end: accepts items, updates the midpoint state and issues octant jobs.
`timescale 1ns / 1ps
module circ_front #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned JOB_W      = 4 * COORD_BITS + 2 + 8 + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  input  logic [COORD_BITS-1:0] radius_i,
  input  logic [circ_pkg::COLOR_W-1:0] color_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output logic [JOB_W-1:0]      job_o
);
  import circ_pkg::*;

  localparam int unsigned XW = COORD_BITS + 1;
  localparam int unsigned DW = COORD_BITS + 5;

  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [XW-1:0]         x_q, x_d;
  logic signed [XW-1:0]  y_q, y_d;
  logic signed [DW-1:0]  d_q, d_d;
  logic [COLOR_W-1:0]    color_q;
  logic                  active_q, active_d;

  logic [XW-1:0]        x_inc;
  logic signed [XW-1:0] y_new, y_start;
  logic signed [DW-1:0] x_ext, y_ext, r_ext, d_step, d_start;
  logic                 go_diag, done;
  logic                 accept, is_start;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_start   = (func_i == FUNC_START);
  assign push_o     = accept && (is_start || active_q);

  always_comb begin
    go_diag = !d_q[DW-1] && (d_q != '0);
    x_inc   = x_q + XW'(1);
    y_new   = go_diag ? (y_q - $signed(XW'(1))) : y_q;
    x_ext   = $signed({{(DW-XW){1'b0}}, x_inc});
    y_ext   = $signed({{(DW-XW){y_new[XW-1]}}, y_new});
    if (go_diag) begin
      d_step = d_q + ((x_ext - y_ext) <<< 2) + $signed(DW'(D_STEP_DIAG));
    end else begin
      d_step = d_q + (x_ext <<< 2) + $signed(DW'(D_STEP_FLAT));
    end
    done    = (y_ext < x_ext);
    r_ext   = $signed({{(DW-COORD_BITS){1'b0}}, radius_i});
    d_start = $signed(DW'(D_INIT)) - (r_ext <<< 1);
    y_start = $signed({1'b0, radius_i});
  end

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    d_d      = d_q;
    active_d = active_q;
    job_o    = {cx_q, cy_q, x_inc, y_new, color_q, done};
    if (is_start) begin
      x_d      = '0;
      y_d      = y_start;
      d_d      = d_start;
      active_d = 1'b1;
      job_o    = {center_x_i, center_y_i, XW'(0), y_start, color_i, 1'b0};
    end else if (active_q) begin
      x_d      = x_inc;
      y_d      = y_new;
      d_d      = d_step;
      active_d = !done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      d_q      <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        cx_q    <= center_x_i;
        cy_q    <= center_y_i;
        color_q <= color_i;
      end
      x_q      <= x_d;
      y_q      <= y_d;
      d_q      <= d_d;
      active_q <= active_d;
    end
  end

  // A final step leaves the circle idle
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !is_start && done) |=> !active_q)
    else $error("active still set after final step");

  // Steps while idle issue no job
  a_idle_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_start && !active_q) |-> !push_o)
    else $error("job issued for step while idle");

endmodule

@@ rtl/circ_fifo.sv @@
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module circ_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);
  import circ_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [CW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue underflow");

endmodule

@@ rtl/circ_back.sv @@
// Back end: expands one octant job into eight pixels through an output register.
`timescale 1ns / 1ps
module circ_back #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned JOB_W      = 4 * COORD_BITS + 2 + 8 + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  logic [JOB_W-1:0]              job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [circ_pkg::PIX_W-1:0] pixel_x_o,
  output logic signed [circ_pkg::PIX_W-1:0] pixel_y_o,
  output logic [circ_pkg::COLOR_W-1:0]  pixel_color_o,
  output logic                          last_of_step_o,
  output logic                          circle_done_o
);
  import circ_pkg::*;

  localparam int unsigned XW = COORD_BITS + 1;
  localparam int unsigned WW = (COORD_BITS + 3 > PIX_W) ? COORD_BITS + 3 : PIX_W;

  logic [JOB_W-1:0] job_q;
  logic             busy_q;
  logic [2:0]       idx_q;

  logic                  out_valid_q;
  logic signed [PIX_W-1:0] px_q, py_q;
  logic [COLOR_W-1:0]    col_q;
  logic                  last_q, done_q;

  logic [COORD_BITS-1:0] j_cx, j_cy;
  logic [XW-1:0]         j_x;
  logic signed [XW-1:0]  j_y;
  logic [COLOR_W-1:0]    j_col;
  logic                  j_done;

  logic signed [WW-1:0] xe, ye, a, b, dx, dy, sx, sy;
  logic                 adv, last_pix;

  assign {j_cx, j_cy, j_x, j_y, j_col, j_done} = job_q;

  assign adv      = busy_q && (!out_valid_q || out_ready_i);
  assign last_pix = (idx_q == PIX_LAST);
  assign pop_o    = job_valid_i && (!busy_q || (adv && last_pix));

  // Index bit 2 swaps x and y, bit 0 negates the column term, bit 1 the row term
  always_comb begin
    xe = $signed({{(WW-XW){1'b0}}, j_x});
    ye = $signed({{(WW-XW){j_y[XW-1]}}, j_y});
    a  = idx_q[2] ? ye : xe;
    b  = idx_q[2] ? xe : ye;
    dx = idx_q[0] ? -a : a;
    dy = idx_q[1] ? -b : b;
    sx = $signed({{(WW-COORD_BITS){1'b0}}, j_cx}) + dx;
    sy = $signed({{(WW-COORD_BITS){1'b0}}, j_cy}) + dy;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (adv) begin
      px_q   <= sx[PIX_W-1:0];
      py_q   <= sy[PIX_W-1:0];
      col_q  <= j_col;
      last_q <= last_pix;
      done_q <= j_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (adv) begin
        idx_q <= idx_q + 3'd1;
        if (last_pix) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_color_o  = col_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (idx_q == '0))
    else $error("pixel index not at zero while idle");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_pix && !pop_o) |=> !busy_q)
    else $error("job not retired after eighth pixel");

endmodule

@@ rtl/circle_rasterizer.sv @@
// Midpoint circle rasterizer top level.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o): an item with func_i = start latches
//    the centre, radius and colour and yields the eight symmetric pixels of the
//    first offset pair; func_i = step advances one midpoint step and yields eight
//    more. A step with no circle in progress yields nothing.
//  - Output channel (out_valid_o / out_ready_i): one pixel per item, eight per
//    emitting input item, last_of_step_o on the eighth, circle_done_o on all
//    pixels of the final step.
//  - Path: an accepted item is written into the job queue, then into the back
//    end's job register; its pixels leave through the output register.
//  - Throughput: one pixel per cycle while out_ready_i is high; the back end's
//    pixel counter over the eight octants sets this rate. The front end computes
//    a whole step in the accept cycle and can run ahead by two queued jobs.
//  - Output stall: pixels hold in the output register; the job queue fills and
//    in_ready_o drops only when both queue entries are taken.
//  - Reset clears the circle state (no circle in progress), empties the queue
//    and drops out_valid_o.
`timescale 1ns / 1ps
module circle_rasterizer #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  input  logic [COORD_BITS-1:0] radius_i,
  input  logic [circ_pkg::COLOR_W-1:0] color_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [circ_pkg::PIX_W-1:0] pixel_x_o,
  output logic signed [circ_pkg::PIX_W-1:0] pixel_y_o,
  output logic [circ_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                  last_of_step_o,
  output logic                  circle_done_o
);
  import circ_pkg::*;

  // Job: centre, x offset, signed y offset, colour, final-step flag
  localparam int unsigned JOB_W = 4 * COORD_BITS + 2 + COLOR_W + 1;

  logic             push, q_full, q_valid, pop;
  logic [JOB_W-1:0] job_in, job_out;

  circ_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .color_i    (color_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  circ_fifo #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  circ_back #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (job_out),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

  // The back end takes a job only when the queue holds one
  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("back end took a job from an empty queue");

  a_ready_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == !q_full)
    else $error("input ready out of step with queue");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !pop) |=> q_full)
    else $error("queue drained without a pop");

endmodule
